/* src/nnact_pkg.sv */
`default_nettype none

package nnact_pkg;

    typedef enum logic [1:0] {
        ACT_RELU    = 2'd0,
        ACT_LEAKY   = 2'd1,
        ACT_SIGMOID = 2'd2
    } t_act_mode;

    typedef enum logic {
        FUNC_FWD = 1'b0,
        FUNC_BWD = 1'b1
    } t_func;

    // Q4.12: 4096 is 1.0, 410 is the leaky slope of about 0.1
    localparam logic signed [16:0] Q_ONE       = 17'sd4096;
    localparam logic signed [16:0] LEAKY_SLOPE = 17'sd410;

    // sigmoid segment breaks, magnitude of x in Q4.12
    localparam logic [16:0] SIG_BRK_SAT = 17'd20480;
    localparam logic [16:0] SIG_BRK_MID = 17'd9728;
    localparam logic [16:0] SIG_BRK_LOW = 17'd4096;
    localparam logic [12:0] SIG_OFS_HI  = 13'd3456;
    localparam logic [12:0] SIG_OFS_MID = 13'd2560;
    localparam logic [12:0] SIG_OFS_LOW = 13'd2048;

endpackage

`default_nettype wire

/* src/nn_activation_unit.sv */
// nn_activation_unit: element-wise activation and gradient in Q4.12.
//
// Input channel i_valid/o_ready carries one element per beat: i_func selects
// forward activation or backward gradient, x_in/y_in/grad/extra_grad are
// the operands and i_last_in is carried along with its element to o_last_out.
// Output channel o_valid/i_ready returns exactly one result per input beat,
// in order.
// Config channel i_cfg_valid/o_cfg_ready writes act_mode (relu, leaky relu,
// sigmoid; code 3 acts as relu). It is always ready; write it only while
// the pipeline is empty. The mode is sampled as each element enters.
// Throughput is one element per cycle while no result is stalled at the
// output: five register stages, with two 17x17 / 16x16 multipliers each
// followed by its own register.
// When i_ready is low with a result waiting, all stages hold together and
// o_ready drops; bubbles are held as well, so no input is taken until the
// waiting result leaves, however empty the earlier stages are.
// Reset clears act_mode to relu and empties the pipeline.

`default_nettype none

module nn_activation_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_func,
    input  wire logic signed [15:0]           i_x_in,
    input  wire logic signed [15:0]           i_y_in,
    input  wire logic signed [15:0]           i_grad,
    input  wire logic signed [15:0]           i_extra_grad,
    input  wire logic                         i_last_in,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [15:0]                o_result,
    output logic                              o_last_out,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_data
);
    import nnact_pkg::*;

    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        logic signed [15:0] r;
        if (v > 22'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -22'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // config
    t_act_mode r_act_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode <= ACT_RELU;
        end else if (i_cfg_valid) begin
            r_act_mode <= t_act_mode'(i_cfg_data);
        end
    end

    // pipeline control: everything moves unless a result is stuck at the tail
    logic [5:1] r_v;
    logic       en;

    assign en      = !r_v[5] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:1], i_valid};
        end
    end

    // ---------------- stage 1: operand prep, sum, sigmoid segments
    logic signed [16:0] sum17;
    logic signed [15:0] n_s;
    logic               x_neg;
    logic [16:0]        x_abs;
    logic [12:0]        sig_pos;
    logic signed [15:0] n_fwd;
    logic signed [16:0] n_a, n_b;
    logic signed [16:0] n_d_step;
    logic               n_fwd_prod, n_d_prod;

    always_comb begin
        sum17 = {i_grad[15], i_grad} + {i_extra_grad[15], i_extra_grad};
        n_s   = sat16({{5{sum17[16]}}, sum17});

        x_neg = i_x_in[15];
        x_abs = x_neg ? (17'd0 - {1'b1, i_x_in}) : {1'b0, i_x_in};

        if (x_abs >= SIG_BRK_SAT) begin
            sig_pos = Q_ONE[12:0];
        end else if (x_abs >= SIG_BRK_MID) begin
            sig_pos = {1'b0, x_abs[16:5]} + SIG_OFS_HI;
        end else if (x_abs >= SIG_BRK_LOW) begin
            sig_pos = x_abs[15:3] + SIG_OFS_MID;
        end else begin
            sig_pos = {1'b0, x_abs[13:2]} + SIG_OFS_LOW;
        end

        // defaults cover relu and the unused code
        n_a        = {i_x_in[15], i_x_in};
        n_b        = LEAKY_SLOPE;
        n_fwd      = x_neg ? 16'sd0 : i_x_in;
        n_fwd_prod = 1'b0;
        n_d_prod   = 1'b0;
        n_d_step   = x_neg ? 17'sd0 : Q_ONE;

        case (r_act_mode)
            ACT_LEAKY: begin
                n_fwd_prod = x_neg;
                n_d_step   = x_neg ? LEAKY_SLOPE : Q_ONE;
            end
            ACT_SIGMOID: begin
                n_a      = {i_y_in[15], i_y_in};
                n_b      = Q_ONE - {i_y_in[15], i_y_in};
                n_fwd    = x_neg ? signed'({3'b000, Q_ONE[12:0] - sig_pos})
                                 : signed'({3'b000, sig_pos});
                n_d_prod = 1'b1;
            end
            default: begin
            end
        endcase
    end

    logic signed [16:0] r1_a, r1_b, r1_d_step;
    logic signed [15:0] r1_s, r1_fwd;
    logic               r1_fwd_prod, r1_d_prod, r1_last;
    t_func              r1_func;
    t_act_mode          r1_mode;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a        <= n_a;
            r1_b        <= n_b;
            r1_d_step   <= n_d_step;
            r1_s        <= n_s;
            r1_fwd      <= n_fwd;
            r1_fwd_prod <= n_fwd_prod;
            r1_d_prod   <= n_d_prod;
            r1_last     <= i_last_in;
            r1_func     <= t_func'(i_func);
            r1_mode     <= r_act_mode;
        end
    end

    // ---------------- stage 2: first multiply (x*slope or y*(1-y))
    logic signed [33:0] r2_p;
    logic signed [16:0] r2_d_step;
    logic signed [15:0] r2_s, r2_fwd;
    logic               r2_fwd_prod, r2_d_prod, r2_last;
    t_func              r2_func;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p        <= r1_a * r1_b;
            r2_d_step   <= r1_d_step;
            r2_s        <= r1_s;
            r2_fwd      <= r1_fwd;
            r2_fwd_prod <= r1_fwd_prod;
            r2_d_prod   <= r1_d_prod;
            r2_last     <= r1_last;
            r2_func     <= r1_func;
        end
    end

    // ---------------- stage 3: scale back, pick forward value and derivative
    logic signed [21:0] q2;
    logic signed [15:0] n3_d, n3_fwd;

    always_comb begin
        q2     = r2_p[33:12];
        n3_fwd = r2_fwd_prod ? q2[15:0] : r2_fwd;
        n3_d   = r2_d_prod ? sat16(q2) : r2_d_step[15:0];
    end

    logic signed [15:0] r3_s, r3_d, r3_fwd;
    logic               r3_last;
    t_func              r3_func;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_s    <= r2_s;
            r3_d    <= n3_d;
            r3_fwd  <= n3_fwd;
            r3_last <= r2_last;
            r3_func <= r2_func;
        end
    end

    // ---------------- stage 4: gradient times derivative
    logic signed [31:0] r4_p;
    logic signed [15:0] r4_fwd;
    logic               r4_last;
    t_func              r4_func;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p    <= r3_s * r3_d;
            r4_fwd  <= r3_fwd;
            r4_last <= r3_last;
            r4_func <= r3_func;
        end
    end

    // ---------------- stage 5: pick forward or backward result, output register
    logic signed [21:0] q4;
    logic signed [15:0] n5_res;

    always_comb begin
        q4     = {{2{r4_p[31]}}, r4_p[31:12]};
        n5_res = (r4_func == FUNC_BWD) ? sat16(q4) : r4_fwd;
    end

    logic signed [15:0] r5_res;
    logic               r5_last;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_res  <= n5_res;
            r5_last <= r4_last;
        end
    end

    assign o_result   = r5_res;
    assign o_last_out = r5_last;

    // ---------------- checks
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[5] |-> o_ready)
        else $error("input blocked with empty output stage");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && en) |=> r_v[5])
        else $error("element lost between stage 4 and output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && !i_ready) |=> (r_v[5] && $stable(r5_res) && $stable(r5_last)))
        else $error("stalled result changed");

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && r1_func == FUNC_FWD && r1_mode == ACT_SIGMOID)
            |-> (r1_fwd >= 16'sd0 && r1_fwd <= 16'sd4096))
        else $error("sigmoid forward out of range");

endmodule

`default_nettype wire
